// File: sv/frame_time_monitor_top_assert.svh
// Assertion macros for the frame time monitor.
`ifndef FRAME_TIME_MONITOR_TOP_ASSERT_SVH
`define FRAME_TIME_MONITOR_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define FTM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ftm_pkg.sv
`default_nettype none
package ftm_pkg;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_STOP  = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;
	localparam logic [1:0] CMD_RESET = 2'd3;

	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] TPS_RESET = 32'd10000000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input beat
		logic update;    // single-cycle update for a beat that needs no divide
		logic div_start; // update window and counters, then load the divider
		logic div_step;  // one quotient bit
		logic div_done;  // write the quotient to the average
		logic out_load;  // load the output register
	} ftm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;  // the captured beat was a running frame tick
		logic div_last;  // final quotient bit this cycle
	} ftm_stat_t;

endpackage
`default_nettype wire

// File: sv/ftm_ctrl.sv
`default_nettype none
module ftm_ctrl
	import ftm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	input  wire ftm_stat_t stat,
	output ftm_cmd_t       cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// One beat at a time: capture, update, optional divide, then the output stage.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.need_div) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					cmd.update = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					cmd.div_done = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// Wait until the previous result beat has drained.
				if (!out_valid || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// File: sv/ftm_datapath.sv
`default_nettype none
module ftm_datapath
	import ftm_pkg::*;
#(
	parameter int SAMPLES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] tps,
	input  wire logic [1:0]  command,
	input  wire logic [63:0] timestamp,
	input  wire ftm_cmd_t    cmd,
	output ftm_stat_t        stat,
	output logic [47:0]      average_frame_ticks,
	output logic [15:0]      frame_rate,
	output logic [63:0]      total_ticks,
	output logic             paused
);

	localparam int IW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int CW = $clog2(SAMPLES + 1);
	localparam int SW = 48 + CW;
	localparam int BW = $clog2(SW + 1);

	logic [47:0] win_mem [SAMPLES];
	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] sum_q;
	logic [47:0] avg_q;
	logic [63:0] last_q, cur_q, base_q, stop_q, ptot_q;
	logic paused_q;
	logic [15:0] frames_q, rate_q;
	logic [47:0] wticks_q;
	logic [1:0] cmd_q;
	logic [63:0] ts_q;
	logic [63:0] ival_q;
	logic [47:0] old_q;
	logic tick_run_q;

	// Divider: restoring, one quotient bit a cycle.
	logic [SW-1:0] rem_q, quo_q;
	logic [BW-1:0] bit_q;

	logic [63:0] diff;
	logic [47:0] samp;
	logic accept, full;
	logic [SW-1:0] sum_next;
	logic [48:0] wt_sum;
	logic [47:0] wt_sat;
	logic [SW:0] rem_sh;
	logic [SW:0] den_x;
	logic [SW-1:0] quo_next;

	// Outlier test, window sum and rate window for a running tick.
	always_comb begin
		diff = (ival_q >= {16'd0, avg_q}) ? ival_q - {16'd0, avg_q}
		                                  : {16'd0, avg_q} - ival_q;
		samp = (ival_q > {16'd0, MAX48}) ? MAX48 : ival_q[47:0];
		accept = diff < {32'd0, tps};
		full = (count_q == CW'(SAMPLES));
		if (accept && full) sum_next = sum_q - SW'(old_q) + SW'(samp);
		else if (accept) sum_next = sum_q + SW'(samp);
		else sum_next = sum_q;
		wt_sum = {1'b0, wticks_q} + {1'b0, samp};
		wt_sat = wt_sum[48] ? MAX48 : wt_sum[47:0];
		rem_sh = {rem_q, quo_q[SW-1]};
		den_x = (SW+1)'(count_q);
		quo_next = {quo_q[SW-2:0], (rem_sh >= den_x)};
		stat.need_div = tick_run_q;
		stat.div_last = (bit_q == BW'(1));
	end

	// Sample window; the oldest sample is read at capture time.
	always_ff @(posedge clk) begin
		if (cmd.load) old_q <= win_mem[head_q];
		if (cmd.div_start && accept) win_mem[head_q] <= samp;
	end

	// Divider registers.
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= sum_next;
		end else if (cmd.div_step) begin
			quo_q <= quo_next;
			rem_q <= (rem_sh >= den_x) ? SW'(rem_sh - den_x) : rem_sh[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0; count_q <= '0; sum_q <= '0;
			avg_q <= '0; last_q <= '0; cur_q <= '0; base_q <= '0;
			stop_q <= '0; ptot_q <= '0; paused_q <= 1'b0;
			frames_q <= '0; rate_q <= '0; wticks_q <= '0;
			cmd_q <= CMD_TICK; ts_q <= '0; ival_q <= '0; tick_run_q <= 1'b0;
			bit_q <= '0;
			average_frame_ticks <= '0; frame_rate <= '0; total_ticks <= '0;
			paused <= 1'b0;
		end else begin
			// Capture the beat and the interval since the last stamp.
			if (cmd.load) begin
				cmd_q <= command;
				ts_q <= timestamp;
				ival_q <= timestamp - last_q;
				tick_run_q <= (command == CMD_TICK) && !paused_q;
			end
			// Running tick: window, counters and stamps.
			if (cmd.div_start) begin
				sum_q <= sum_next;
				if (accept) begin
					head_q <= (head_q == IW'(SAMPLES - 1)) ? '0 : head_q + IW'(1);
					if (!full) count_q <= count_q + CW'(1);
				end
				if (wt_sat > {16'd0, tps}) begin
					rate_q <= (frames_q == 16'hFFFF) ? frames_q : frames_q + 16'd1;
					frames_q <= '0;
					wticks_q <= '0;
				end else begin
					if (frames_q != 16'hFFFF) frames_q <= frames_q + 16'd1;
					wticks_q <= wt_sat;
				end
				last_q <= ts_q;
				cur_q <= ts_q;
				bit_q <= BW'(SW);
			end
			if (cmd.div_step) bit_q <= bit_q - BW'(1);
			if (cmd.div_done) begin
				avg_q <= (count_q == CW'(0)) ? '0 : quo_next[47:0];
			end
			// Commands that need no divide.
			if (cmd.update) begin
				case (cmd_q)
					CMD_TICK: avg_q <= '0;
					CMD_STOP: if (!paused_q) begin
						stop_q <= ts_q; paused_q <= 1'b1;
					end
					CMD_START: if (paused_q) begin
						ptot_q <= ptot_q + (ts_q - stop_q);
						last_q <= ts_q; stop_q <= '0; paused_q <= 1'b0;
					end
					CMD_RESET: begin
						base_q <= ts_q; last_q <= ts_q; cur_q <= ts_q;
						stop_q <= '0; ptot_q <= '0; paused_q <= 1'b0;
					end
					default: ;
				endcase
			end
			// Output register.
			if (cmd.out_load) begin
				average_frame_ticks <= avg_q;
				frame_rate <= rate_q;
				total_ticks <= (paused_q ? stop_q : cur_q) - ptot_q - base_q;
				paused <= paused_q;
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/frame_time_monitor_top.sv
// Frame time monitor: each input beat gives one output beat.
// Stop, start, reset or a paused tick go through capture, update and the output
// register; a running tick adds the bit-serial window divide before the output.
// A new beat is taken only after the previous one is loaded into the output register.
// Reset: arst_n clears all control and statistics state and ticks_per_second
// returns to 10000000; the sample window is not cleared.
`default_nettype none
module frame_time_monitor_top
	import ftm_pkg::*;
#(
	parameter int SAMPLES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] ticks_per_second,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [63:0] timestamp,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [47:0]      average_frame_ticks,
	output logic [15:0]      frame_rate,
	output logic [63:0]      total_ticks,
	output logic             paused
);

	logic [31:0] tps_q;
	ftm_cmd_t  cmd;
	ftm_stat_t stat;

	// Configuration register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tps_q <= TPS_RESET;
		else if (cfg_valid) tps_q <= ticks_per_second;
	end

	ftm_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
	);

	ftm_datapath #(.SAMPLES(SAMPLES)) u_dp (
		.clk, .arst_n, .tps(tps_q), .command, .timestamp, .cmd, .stat,
		.average_frame_ticks, .frame_rate, .total_ticks, .paused
	);

endmodule
`default_nettype wire

// File: sv/ftm_checker.sv
`default_nettype none
`include "frame_time_monitor_top_assert.svh"
module ftm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [47:0] average_frame_ticks,
	input wire logic        paused
);

	logic out_wait;
	assign out_wait = out_valid && out_stall;

	// A stalled result keeps its average.
	`FTM_ASSERT_NEXT(a_hold, clk, arst_n, out_wait, $stable(average_frame_ticks), "avg changed")
	// An accepted beat blocks the input until its result is shown.
	`FTM_ASSERT_NEXT(a_block, clk, arst_n, in_valid && !in_stall, in_stall, "input taken twice")
	// A stalled result stays valid.
	`FTM_ASSERT_NEXT(a_valid, clk, arst_n, out_wait, out_valid && $stable(paused), "valid dropped")

endmodule

bind frame_time_monitor_top ftm_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.average_frame_ticks, .paused
);
`default_nettype wire
